// File: sv/dtt_pkg.sv
// Shared types, constants and helpers for the deadline timer table.
// No dependencies; every other file of the block imports this package.
package dtt_pkg;

  // Table geometry
  localparam int SLOTS  = 16;
  localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  // Field widths
  localparam int TIME_W = 48;
  localparam int PER_W  = 32;
  localparam int ID_W   = 4;
  localparam int KIND_W = 3;
  localparam int ACT_W  = 2;

  // At most this many expired timers are reported by one collect
  localparam int MAXRES = 16;
  localparam int NRES_W = $clog2(MAXRES + 1);

  // Action codes
  localparam logic [ACT_W-1:0] ACT_ADD     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_COLLECT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY   = 2'd2;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    K_ADDED   = 3'd0,
    K_FULL    = 3'd1,
    K_EXPIRED = 3'd2,
    K_NONE    = 3'd3,
    K_DELAY   = 3'd4
  } kind_t;

  // One slot of the timer memory
  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [PER_W-1:0]  period;
    logic              rearm;
  } slot_t;

  // One result item
  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   timer_id;
    logic [TIME_W-1:0] delay_ms;
    logic              table_empty;
    logic              wake;
    logic              last;
  } result_t;

  // Add a period to the current time, clamp at the largest time value
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] now,
                                                input logic [PER_W-1:0]  per);
    logic [TIME_W:0] sum;
    sum = {1'b0, now} + {{(TIME_W + 1 - PER_W){1'b0}}, per};
    return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  endfunction

  // Timer order: by deadline, ties broken by slot index
  function automatic logic key_lt(input logic [TIME_W-1:0] da,
                                  input logic [SW-1:0]     ia,
                                  input logic [TIME_W-1:0] db,
                                  input logic [SW-1:0]     ib);
    return (da < db) || ((da == db) && (ia < ib));
  endfunction

  // Slot index as a handle, masked to the handle width
  function automatic logic [ID_W-1:0] to_id(input logic [SW-1:0] idx);
    return ID_W'(idx);
  endfunction

endpackage

// File: sv/dtt_slot_ram.sv
// Slot memory: deadline, period and rearm mark of every timer.
// One write port, one read port with registered data; uses dtt_pkg.
module dtt_slot_ram import dtt_pkg::*; (
  input  logic          clk,
  input  logic          we,
  input  logic [SW-1:0] waddr,
  input  slot_t         wdata,
  input  logic [SW-1:0] raddr,
  output slot_t         rdata
);

  slot_t mem [SLOTS];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read: the entry appears in the cycle after its address
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/dtt_out_buf.sv
// Output register for result items, decoupling the sequencer from a stalled receiver.
// Uses the result_t type of dtt_pkg.
module dtt_out_buf import dtt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t din,
  output logic    ready,
  input  logic    stall,
  output logic    valid,
  output result_t dout
);

  // Take a new item when empty or when the held one leaves this cycle
  assign ready = !valid || !stall;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  // Hold the payload until replaced
  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule

// File: sv/deadline_timer_table_unit.sv
// Deadline timer table: sequencer, scan compare logic and slot bookkeeping.
// Instantiates dtt_slot_ram and dtt_out_buf; uses dtt_pkg.
//
// Usage: one input channel (in_valid / in_stall) carries an action with the
// current time; one output channel (out_valid / out_stall) returns result items.
// Add and query give one result; collect gives one result per expired timer,
// earliest first, with last set on the final one, or a single "nothing expired".
// The block takes one item at a time. Every action scans all slots through the
// single read port of the slot memory, except an add to a full table, which
// answers without a scan. A collect of n timers runs one scan per reported
// timer, one more scan that finds none unless MAXRES timers were reported,
// and, if any were reported, one rearm/free sweep.
// Results sit in an output register; while the receiver stalls, the block
// finishes its current scan and waits with the next result, and in_stall stays
// high until the item is complete. Reset (rst, synchronous) empties the table
// and clears the pending wake at once; no clearing pass is needed.
module deadline_timer_table_unit import dtt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ACT_W-1:0]  action,
  input  logic [TIME_W-1:0] now_time,
  input  logic [PER_W-1:0]  period_ms,
  input  logic              recurring,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KIND_W-1:0] kind,
  output logic [ID_W-1:0]   timer_id,
  output logic [TIME_W-1:0] delay_ms,
  output logic              table_empty,
  output logic              wake,
  output logic              last
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_ADD_SCAN = 7'b0000010,
    S_QRY_SCAN = 7'b0000100,
    S_COL_SCAN = 7'b0001000,
    S_COL_LAST = 7'b0010000,
    S_COL_UPD  = 7'b0100000,
    S_EMIT     = 7'b1000000
  } state_t;

  state_t            state;
  state_t            emit_ret;
  logic [SLOTS-1:0]  used;
  logic              wake_pending;

  // Latched item
  logic [TIME_W-1:0] now_r;
  logic [SW-1:0]     new_slot;
  logic [TIME_W-1:0] new_dl;
  logic [PER_W-1:0]  new_per;
  logic              new_rep;

  // Scan pipeline
  logic [CNT_W-1:0]  cnt;
  logic              rd_vld;
  logic [SW-1:0]     rd_idx;
  slot_t             rd_data;
  logic              scan_active;
  logic              issue;
  logic              scan_done;

  // Candidates and collect progress
  logic              best_found;
  logic [TIME_W-1:0] best_dl;
  logic [SW-1:0]     best_idx;
  logic              any_earlier;
  logic              have_last;
  logic [TIME_W-1:0] last_dl;
  logic [SW-1:0]     last_idx;
  logic              pend_valid;
  logic [SW-1:0]     pend_idx;
  logic [NRES_W-1:0] n_cnt;

  // Element tests
  logic              elem_used;
  logic              elem_due;
  logic              elem_after_last;
  logic              elem_before_best;
  logic              take_qry;
  logic              take_col;
  logic              earlier_new;
  logic              upd_hit;

  // Free slot search
  logic              free_found;
  logic [SW-1:0]     free_idx;

  // Memory write port
  logic              mem_we;
  logic [SW-1:0]     mem_waddr;
  slot_t             mem_wdata;

  // Result path
  result_t           res;
  result_t           out_res;
  logic              buf_ready;
  logic              out_load;
  logic [TIME_W-1:0] qry_delay;
  logic              add_wake;

  function automatic result_t mk_res(input kind_t k, input logic [ID_W-1:0] id,
                                     input logic [TIME_W-1:0] dly, input logic emp,
                                     input logic wk, input logic lst);
    result_t r;
    r.kind        = k;
    r.timer_id    = id;
    r.delay_ms    = dly;
    r.table_empty = emp;
    r.wake        = wk;
    r.last        = lst;
    return r;
  endfunction

  assign in_stall = (state != S_IDLE);

  // Find the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  // Sweep addresses through the memory read port
  assign scan_active = (state == S_ADD_SCAN) || (state == S_QRY_SCAN) ||
                       (state == S_COL_SCAN) || (state == S_COL_UPD);
  assign issue       = scan_active && (cnt != CNT_W'(SLOTS));
  assign scan_done   = scan_active && (cnt == CNT_W'(SLOTS)) && !rd_vld;

  // Compare the returned entry against candidates
  assign elem_used        = used[rd_idx];
  assign elem_due         = (rd_data.deadline <= now_r);
  assign elem_after_last  = !have_last || key_lt(last_dl, last_idx, rd_data.deadline, rd_idx);
  assign elem_before_best = !best_found || key_lt(rd_data.deadline, rd_idx, best_dl, best_idx);
  assign take_qry         = rd_vld && elem_used && elem_before_best;
  assign take_col         = take_qry && elem_due && elem_after_last;
  assign earlier_new      = rd_vld && elem_used &&
                            key_lt(rd_data.deadline, rd_idx, new_dl, new_slot);
  assign upd_hit          = rd_vld && elem_used && elem_due &&
                            !key_lt(last_dl, last_idx, rd_data.deadline, rd_idx);

  assign qry_delay = (best_found && (best_dl > now_r)) ? (best_dl - now_r) : '0;
  assign add_wake  = !any_earlier && !wake_pending;

  // Write the new timer at the end of an add, rearm during the collect sweep
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_idx;
    mem_wdata = rd_data;
    if ((state == S_ADD_SCAN) && scan_done) begin
      mem_we          = 1'b1;
      mem_waddr       = new_slot;
      mem_wdata.deadline = new_dl;
      mem_wdata.period   = new_per;
      mem_wdata.rearm    = new_rep;
    end else if ((state == S_COL_UPD) && upd_hit && rd_data.rearm) begin
      mem_we             = 1'b1;
      mem_wdata.deadline = sat_add(now_r, rd_data.period);
    end
  end

  assign out_load = (state == S_EMIT) && buf_ready;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      emit_ret     <= S_IDLE;
      used         <= '0;
      wake_pending <= 1'b0;
      rd_vld       <= 1'b0;
      cnt          <= '0;
      best_found   <= 1'b0;
      any_earlier  <= 1'b0;
      have_last    <= 1'b0;
      pend_valid   <= 1'b0;
      n_cnt        <= '0;
    end else begin
      // advance the scan
      rd_vld <= issue;
      rd_idx <= cnt[SW-1:0];
      if (issue) begin
        cnt <= cnt + 1'b1;
      end

      // track candidates
      if ((state == S_ADD_SCAN) && earlier_new) begin
        any_earlier <= 1'b1;
      end
      if (((state == S_QRY_SCAN) && take_qry) || ((state == S_COL_SCAN) && take_col)) begin
        best_found <= 1'b1;
        best_dl    <= rd_data.deadline;
        best_idx   <= rd_idx;
      end

      // free reported one-shot timers
      if ((state == S_COL_UPD) && upd_hit && !rd_data.rearm) begin
        used[rd_idx] <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            now_r       <= now_time;
            cnt         <= '0;
            best_found  <= 1'b0;
            any_earlier <= 1'b0;
            case (action)
              ACT_ADD: begin
                if (free_found) begin
                  new_slot <= free_idx;
                  new_dl   <= sat_add(now_time, period_ms);
                  new_per  <= period_ms;
                  new_rep  <= recurring;
                  state    <= S_ADD_SCAN;
                end else begin
                  res      <= mk_res(K_FULL, '0, '0, 1'b0, 1'b0, 1'b1);
                  emit_ret <= S_IDLE;
                  state    <= S_EMIT;
                end
              end
              ACT_COLLECT: begin
                have_last  <= 1'b0;
                pend_valid <= 1'b0;
                n_cnt      <= '0;
                state      <= S_COL_SCAN;
              end
              ACT_QUERY: begin
                wake_pending <= 1'b0;
                state        <= S_QRY_SCAN;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        S_ADD_SCAN: begin
          if (scan_done) begin
            used[new_slot] <= 1'b1;
            if (add_wake) begin
              wake_pending <= 1'b1;
            end
            res      <= mk_res(K_ADDED, to_id(new_slot), '0, 1'b0, add_wake, 1'b1);
            emit_ret <= S_IDLE;
            state    <= S_EMIT;
          end
        end

        S_QRY_SCAN: begin
          if (scan_done) begin
            res      <= mk_res(K_DELAY, '0, qry_delay, !best_found, 1'b0, 1'b1);
            emit_ret <= S_IDLE;
            state    <= S_EMIT;
          end
        end

        S_COL_SCAN: begin
          if (scan_done) begin
            if (best_found) begin
              // hold the new find, send the previous one
              pend_idx   <= best_idx;
              pend_valid <= 1'b1;
              last_dl    <= best_dl;
              last_idx   <= best_idx;
              have_last  <= 1'b1;
              n_cnt      <= n_cnt + 1'b1;
              cnt        <= '0;
              best_found <= 1'b0;
              if (pend_valid) begin
                res      <= mk_res(K_EXPIRED, to_id(pend_idx), '0, 1'b0, 1'b0, 1'b0);
                emit_ret <= (n_cnt == NRES_W'(MAXRES - 1)) ? S_COL_LAST : S_COL_SCAN;
                state    <= S_EMIT;
              end else begin
                state <= (n_cnt == NRES_W'(MAXRES - 1)) ? S_COL_LAST : S_COL_SCAN;
              end
            end else if (pend_valid) begin
              state <= S_COL_LAST;
            end else begin
              res      <= mk_res(K_NONE, '0, '0, 1'b0, 1'b0, 1'b1);
              emit_ret <= S_IDLE;
              state    <= S_EMIT;
            end
          end
        end

        S_COL_LAST: begin
          res      <= mk_res(K_EXPIRED, to_id(pend_idx), '0, 1'b0, 1'b0, 1'b1);
          emit_ret <= S_COL_UPD;
          cnt      <= '0;
          state    <= S_EMIT;
        end

        S_COL_UPD: begin
          if (scan_done) begin
            state <= S_IDLE;
          end
        end

        S_EMIT: begin
          if (buf_ready) begin
            state <= emit_ret;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  dtt_slot_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (cnt[SW-1:0]),
    .rdata (rd_data)
  );

  dtt_out_buf u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (out_load),
    .din   (res),
    .ready (buf_ready),
    .stall (out_stall),
    .valid (out_valid),
    .dout  (out_res)
  );

  // Drive the result fields
  assign kind        = out_res.kind;
  assign timer_id    = out_res.timer_id;
  assign delay_ms    = out_res.delay_ms;
  assign table_empty = out_res.table_empty;
  assign wake        = out_res.wake;
  assign last        = out_res.last;

endmodule
